// ----- rtl/ecbl_pkg.sv -----
`default_nettype none

package ecbl_pkg;

    // map geometry
    localparam int MAP_BITS = 16;
    localparam int PREV_BITS = MAP_BITS - 1;
    localparam int MAP_DEPTH = 1 << MAP_BITS;

    // fixed field widths
    localparam int ADDR_W = 64;
    localparam int RIDX_W = 16;
    localparam int IDX_W = 16;
    localparam int CNT_W = 8;
    localparam int RATIO_W = 7;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W = 2;

    // scrambler shifts
    localparam int HASH_SHR = 4;
    localparam int HASH_SHL = 8;

    // ratio limits and the width of the scaled limit compare
    localparam int RATIO_MAX = 100;
    localparam int RATIO_MIN = 1;
    localparam int LIM_W = MAP_BITS + 8;

    typedef logic [MAP_BITS-1:0] map_idx_t;
    typedef logic [PREV_BITS-1:0] prev_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [LIM_W-1:0] lim_t;
    typedef logic [RATIO_W-1:0] ratio_t;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODE_START = 2'd0,
        REG_CODE_END = 2'd1,
        REG_RATIO = 2'd2,
        REG_MAP_ENABLE = 2'd3
    } reg_idx_t;

    // opcodes
    localparam logic OP_LOG = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [ADDR_W-1:0] code_start;
        logic [ADDR_W-1:0] code_end;
        lim_t limit_scaled;
        logic map_enable;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/ecbl_cfg.sv -----
`default_nettype none

module ecbl_cfg (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic cfg_wr_en,
    input wire logic [ecbl_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic [ecbl_pkg::CFG_DATA_W-1:0] cfg_data,
    output ecbl_pkg::cfg_t cfg
);

    logic [ecbl_pkg::ADDR_W-1:0] code_start_reg;
    logic [ecbl_pkg::ADDR_W-1:0] code_end_reg;
    ecbl_pkg::ratio_t ratio_reg;
    logic map_enable_reg;
    ecbl_pkg::ratio_t ratio_raw;
    ecbl_pkg::ratio_t ratio_next;

    // clamp the ratio to 1..100 as it is written
    always_comb begin
        ratio_raw = cfg_data[ecbl_pkg::RATIO_W-1:0];
        if (ratio_raw > ecbl_pkg::ratio_t'(ecbl_pkg::RATIO_MAX)) begin
            ratio_next = ecbl_pkg::ratio_t'(ecbl_pkg::RATIO_MAX);
        end else if (ratio_raw == '0) begin
            ratio_next = ecbl_pkg::ratio_t'(ecbl_pkg::RATIO_MIN);
        end else begin
            ratio_next = ratio_raw;
        end
    end

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_start_reg <= '0;
            code_end_reg <= '1;
            ratio_reg <= ecbl_pkg::ratio_t'(ecbl_pkg::RATIO_MAX);
            map_enable_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (ecbl_pkg::reg_idx_t'(cfg_index))
                ecbl_pkg::REG_CODE_START: code_start_reg <= cfg_data;
                ecbl_pkg::REG_CODE_END: code_end_reg <= cfg_data;
                ecbl_pkg::REG_RATIO: ratio_reg <= ratio_next;
                ecbl_pkg::REG_MAP_ENABLE: map_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // limit scaled by 100: hash is instrumented when 100*(hash+1) <= ratio*2**MAP_BITS
    always_comb begin
        cfg.code_start = code_start_reg;
        cfg.code_end = code_end_reg;
        cfg.limit_scaled = ecbl_pkg::lim_t'(ratio_reg) << ecbl_pkg::MAP_BITS;
        cfg.map_enable = map_enable_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/ecbl_map_ram.sv -----
`default_nettype none

module ecbl_map_ram (
    input wire logic aclk,
    input wire logic wr_en,
    input wire ecbl_pkg::map_idx_t wr_addr,
    input wire ecbl_pkg::cnt_t wr_data,
    input wire logic rd_en,
    input wire ecbl_pkg::map_idx_t rd_addr,
    output ecbl_pkg::cnt_t rd_data
);

    ecbl_pkg::cnt_t mem [ecbl_pkg::MAP_DEPTH];
    ecbl_pkg::cnt_t rd_data_reg;

    // single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/edge_coverage_bitmap_logger.sv -----
`default_nettype none

// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+-------------------------------------------
// input     | in        | s_valid / s_ready   | s_opcode, s_block_address, s_read_index
// result    | out       | m_valid / m_ready   | m_logged, m_entry_index, m_entry_count
// config    | in        | cfg_wr_en           | cfg_index, cfg_data
//
// each transaction passes through accept, counter lookup and counter update in
// turn; the counter is read, then written back, and no new one is accepted until then.
// after reset the counter memory is cleared one entry per cycle, all 2**MAP_BITS
// entries (65536 at 16 bits); s_ready stays low meanwhile, config writes are taken.
// a result waits in the output register; the update step stalls until it is free.

module edge_coverage_bitmap_logger (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    output logic s_ready,
    input wire logic s_opcode,
    input wire logic [ecbl_pkg::ADDR_W-1:0] s_block_address,
    input wire logic [ecbl_pkg::RIDX_W-1:0] s_read_index,
    output logic m_valid,
    input wire logic m_ready,
    output logic m_logged,
    output logic [ecbl_pkg::IDX_W-1:0] m_entry_index,
    output logic [ecbl_pkg::CNT_W-1:0] m_entry_count,
    input wire logic cfg_wr_en,
    input wire logic [ecbl_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic [ecbl_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    ecbl_pkg::cfg_t cfg;

    state_t state_reg, state_next;
    ecbl_pkg::map_idx_t clr_cnt_reg, clr_cnt_next;
    ecbl_pkg::prev_t prev_reg, prev_next;
    logic m_valid_reg, m_valid_next;

    // captured transaction
    logic op_reg, op_next;
    logic [ecbl_pkg::ADDR_W-1:0] addr_reg, addr_next;
    ecbl_pkg::map_idx_t ridx_reg, ridx_next;

    // lookup results
    logic hit_reg, hit_next;
    ecbl_pkg::map_idx_t entry_reg, entry_next;
    ecbl_pkg::map_idx_t hash_reg, hash_next;

    // output payload
    logic m_logged_reg, m_logged_next;
    logic [ecbl_pkg::IDX_W-1:0] m_entry_index_reg, m_entry_index_next;
    ecbl_pkg::cnt_t m_entry_count_reg, m_entry_count_next;

    // memory port
    logic ram_wr_en;
    ecbl_pkg::map_idx_t ram_wr_addr;
    ecbl_pkg::cnt_t ram_wr_data;
    logic ram_rd_en;
    ecbl_pkg::cnt_t ram_rd_data;

    // datapath helpers
    logic in_range;
    ecbl_pkg::map_idx_t hash;
    ecbl_pkg::lim_t hash_scaled;
    logic below_limit;
    ecbl_pkg::cnt_t count_inc;
    logic out_free;

    ecbl_cfg u_cfg (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cfg(cfg)
    );

    ecbl_map_ram u_map_ram (
        .aclk(aclk),
        .wr_en(ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en(ram_rd_en),
        .rd_addr(entry_next),
        .rd_data(ram_rd_data)
    );

    // address filter, scrambler, limit check, counter increment and output-free flag
    always_comb begin
        in_range = cfg.map_enable && (addr_reg >= cfg.code_start)
            && (addr_reg <= cfg.code_end);
        hash = ecbl_pkg::map_idx_t'(addr_reg >> ecbl_pkg::HASH_SHR)
            ^ ecbl_pkg::map_idx_t'(addr_reg << ecbl_pkg::HASH_SHL);
        hash_scaled = (ecbl_pkg::lim_t'(hash) + ecbl_pkg::lim_t'(1))
            * ecbl_pkg::lim_t'(ecbl_pkg::RATIO_MAX);
        below_limit = hash_scaled <= cfg.limit_scaled;
        count_inc = ram_rd_data + ecbl_pkg::cnt_t'(1);
        out_free = !m_valid_reg || m_ready;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        clr_cnt_next = clr_cnt_reg;
        prev_next = prev_reg;
        m_valid_next = m_valid_reg && !m_ready;
        op_next = op_reg;
        addr_next = addr_reg;
        ridx_next = ridx_reg;
        hit_next = hit_reg;
        entry_next = entry_reg;
        hash_next = hash_reg;
        m_logged_next = m_logged_reg;
        m_entry_index_next = m_entry_index_reg;
        m_entry_count_next = m_entry_count_reg;
        ram_wr_en = 1'b0;
        ram_wr_addr = entry_reg;
        ram_wr_data = count_inc;
        ram_rd_en = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en = 1'b1;
                ram_wr_addr = clr_cnt_reg;
                ram_wr_data = '0;
                clr_cnt_next = clr_cnt_reg + ecbl_pkg::map_idx_t'(1);
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next = s_opcode;
                    addr_next = s_block_address;
                    ridx_next = ecbl_pkg::map_idx_t'(s_read_index);
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // read the counter for the edge or the requested entry
                hit_next = (op_reg == ecbl_pkg::OP_LOG) && in_range && below_limit;
                hash_next = hash;
                if (op_reg == ecbl_pkg::OP_READ) begin
                    entry_next = ridx_reg;
                end else begin
                    entry_next = hash ^ {1'b0, prev_reg};
                end
                ram_rd_en = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    ram_wr_en = hit_reg;
                    m_valid_next = 1'b1;
                    m_logged_next = hit_reg;
                    if (op_reg == ecbl_pkg::OP_READ) begin
                        m_entry_index_next = ecbl_pkg::IDX_W'(entry_reg);
                        m_entry_count_next = ram_rd_data;
                    end else if (hit_reg) begin
                        m_entry_index_next = ecbl_pkg::IDX_W'(entry_reg);
                        m_entry_count_next = count_inc;
                        prev_next = hash_reg[ecbl_pkg::MAP_BITS-1:1];
                    end else begin
                        m_entry_index_next = '0;
                        m_entry_count_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        addr_reg <= addr_next;
        ridx_reg <= ridx_next;
        hit_reg <= hit_next;
        entry_reg <= entry_next;
        hash_reg <= hash_next;
        m_logged_reg <= m_logged_next;
        m_entry_index_reg <= m_entry_index_next;
        m_entry_count_reg <= m_entry_count_next;
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_cnt_reg <= '0;
            prev_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            prev_reg <= prev_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_logged = m_logged_reg;
    assign m_entry_index = m_entry_index_reg;
    assign m_entry_count = m_entry_count_reg;

endmodule

`default_nettype wire
